// ===== hw/rtl/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbp_pkg
// shared constants, codes and controller/datapath types of the handle pool
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = 4;
  localparam int QDEPTH     = 16;
  localparam int QPTR_W     = 4;
  localparam int CNT_W      = 5;
  localparam int TIME_W     = 32;
  localparam int TAG_W      = 8;
  localparam int MASK_W     = 16;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_ACQUIRE  = 3'd1,
    REQ_ACQ_WAIT = 3'd2,
    REQ_RELEASE  = 3'd3,
    REQ_HEALTH   = 3'd4,
    REQ_CLEANUP  = 3'd5,
    REQ_PREWARM  = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    RSP_GRANTED    = 4'd0,
    RSP_FAILED     = 4'd1,
    RSP_QUEUED     = 4'd2,
    RSP_QUEUE_FULL = 4'd3,
    RSP_TO_WAITER  = 4'd4,
    RSP_IDLED      = 4'd5,
    RSP_DESTROYED  = 4'd6,
    RSP_REPLACED   = 4'd7,
    RSP_DONE       = 4'd8,
    RSP_BAD_SLOT   = 4'd9
  } rsp_t;

  typedef enum logic [1:0] {
    SS_FREE   = 2'd0,
    SS_IDLE   = 2'd1,
    SS_ACTIVE = 2'd2
  } slot_st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TOTAL    = 2'd0,
    CFG_MIN_IDLE     = 2'd1,
    CFG_IDLE_TIMEOUT = 2'd2,
    CFG_MAX_LIFETIME = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ACQ_POP,
    S_ACQ_CHK,
    S_ACQ_CREATE,
    S_GRANT,
    S_REL_CHK,
    S_REFILL,
    S_SW_RD,
    S_SW_CHK,
    S_CMP,
    S_PW,
    S_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_ENQ,
    OP_QFULL,
    OP_FAIL,
    OP_POP,
    OP_DESTROY,
    OP_CREATE,
    OP_GRANT,
    OP_REL_BAD,
    OP_REL_RD,
    OP_REL_DESTROY,
    OP_REFILL,
    OP_HANDOVER,
    OP_IDLE_RET,
    OP_SW_RD,
    OP_SW_EVAL,
    OP_CMP,
    OP_CMP_END,
    OP_PW,
    OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    req_t             req;
    logic             idle_empty;
    logic             under_cap;
    logic             can_create;
    logic             qfull;
    logic             qhas;
    logic             slot_active;
    logic             pop_bad;
    logic             rel_drop;
    logic             sweep_done;
    logic             cmp_done;
    logic             pw_more;
    logic             refill_need;
    logic             out_free;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] active;
    logic [CNT_W-1:0] fill;
  } stat_t;

  function automatic logic aged(input logic [TIME_W-1:0] now,
                                input logic [TIME_W-1:0] stamp,
                                input logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] age;
    age = now - stamp;
    return (limit != '0) && (age >= limit);
  endfunction

endpackage

// ===== hw/rtl/hbp_in_if.sv =====
// ----------------------------------------------------------------------------
// hbp_in_if
// request channel of the handle pool
// ----------------------------------------------------------------------------
interface hbp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hbp_pkg::REQ_W-1:0]    req_type;
  logic [hbp_pkg::SLOT_W-1:0]   slot_id;
  logic                         healthy;
  logic [hbp_pkg::TAG_W-1:0]    waiter_tag;
  logic [hbp_pkg::MASK_W-1:0]   valid_mask;
  logic                         create_ok;
  logic [hbp_pkg::CNT_W-1:0]    prewarm_count;

  modport source (output valid, req_type, slot_id, healthy, waiter_tag, valid_mask,
                  create_ok, prewarm_count, input ready);
  modport sink (input valid, req_type, slot_id, healthy, waiter_tag, valid_mask,
                create_ok, prewarm_count, output ready);
endinterface

// ===== hw/rtl/hbp_out_if.sv =====
// ----------------------------------------------------------------------------
// hbp_out_if
// result channel of the handle pool
// ----------------------------------------------------------------------------
interface hbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hbp_pkg::STAT_W-1:0]   status;
  logic [hbp_pkg::SLOT_W-1:0]   granted_slot;
  logic [hbp_pkg::TAG_W-1:0]    served_tag;
  logic [hbp_pkg::CNT_W-1:0]    affected_count;
  logic [hbp_pkg::CNT_W-1:0]    total_handles;
  logic [hbp_pkg::CNT_W-1:0]    idle_handles;
  logic [hbp_pkg::CNT_W-1:0]    active_handles;
  logic [hbp_pkg::CNT_W-1:0]    waiting_requests;

  modport source (output valid, status, granted_slot, served_tag, affected_count,
                  total_handles, idle_handles, active_handles, waiting_requests,
                  input ready);
  modport sink (input valid, status, granted_slot, served_tag, affected_count,
                total_handles, idle_handles, active_handles, waiting_requests,
                output ready);
endinterface

// ===== hw/rtl/hbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbp_ctrl
// request sequencer: walks each request through datapath steps
// ----------------------------------------------------------------------------
module hbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hbp_pkg::stat_t  stat,
  output hbp_pkg::cmd_t   cmd
);

  hbp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hbp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hbp_pkg::S_DISPATCH;
      end
      hbp_pkg::S_DISPATCH: begin
        case (stat.req)
          hbp_pkg::REQ_ACQUIRE: state_nxt = hbp_pkg::S_ACQ_POP;
          hbp_pkg::REQ_ACQ_WAIT: begin
            if (!stat.idle_empty || stat.under_cap) state_nxt = hbp_pkg::S_ACQ_POP;
            else state_nxt = hbp_pkg::S_RESP;
          end
          hbp_pkg::REQ_RELEASE: begin
            if (stat.slot_active) state_nxt = hbp_pkg::S_REL_CHK;
            else state_nxt = hbp_pkg::S_RESP;
          end
          hbp_pkg::REQ_HEALTH, hbp_pkg::REQ_CLEANUP: state_nxt = hbp_pkg::S_SW_RD;
          hbp_pkg::REQ_PREWARM: state_nxt = hbp_pkg::S_PW;
          default: state_nxt = hbp_pkg::S_RESP;
        endcase
      end
      hbp_pkg::S_ACQ_POP: begin
        if (stat.idle_empty) state_nxt = hbp_pkg::S_ACQ_CREATE;
        else state_nxt = hbp_pkg::S_ACQ_CHK;
      end
      hbp_pkg::S_ACQ_CHK: begin
        if (stat.pop_bad) state_nxt = hbp_pkg::S_ACQ_POP;
        else state_nxt = hbp_pkg::S_RESP;
      end
      hbp_pkg::S_ACQ_CREATE: begin
        if (stat.can_create) state_nxt = hbp_pkg::S_GRANT;
        else state_nxt = hbp_pkg::S_RESP;
      end
      hbp_pkg::S_GRANT: state_nxt = hbp_pkg::S_RESP;
      hbp_pkg::S_REL_CHK: begin
        if (stat.rel_drop) state_nxt = hbp_pkg::S_REFILL;
        else state_nxt = hbp_pkg::S_RESP;
      end
      hbp_pkg::S_REFILL: state_nxt = hbp_pkg::S_RESP;
      hbp_pkg::S_SW_RD: begin
        if (stat.sweep_done) state_nxt = hbp_pkg::S_CMP;
        else state_nxt = hbp_pkg::S_SW_CHK;
      end
      hbp_pkg::S_SW_CHK: state_nxt = hbp_pkg::S_SW_RD;
      hbp_pkg::S_CMP: begin
        if (stat.cmp_done) state_nxt = hbp_pkg::S_RESP;
      end
      hbp_pkg::S_PW: begin
        if (!(stat.pw_more && stat.can_create)) state_nxt = hbp_pkg::S_RESP;
      end
      hbp_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = hbp_pkg::S_IDLE;
      end
      default: state_nxt = hbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = hbp_pkg::OP_NONE;
    case (state_r)
      hbp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = hbp_pkg::OP_LOAD;
      end
      hbp_pkg::S_DISPATCH: begin
        case (stat.req)
          hbp_pkg::REQ_TICK: cmd.op = hbp_pkg::OP_TICK;
          hbp_pkg::REQ_ACQ_WAIT: begin
            if (!stat.idle_empty || stat.under_cap) cmd.op = hbp_pkg::OP_NONE;
            else if (stat.qfull) cmd.op = hbp_pkg::OP_QFULL;
            else cmd.op = hbp_pkg::OP_ENQ;
          end
          hbp_pkg::REQ_RELEASE: begin
            if (stat.slot_active) cmd.op = hbp_pkg::OP_REL_RD;
            else cmd.op = hbp_pkg::OP_REL_BAD;
          end
          default: cmd.op = hbp_pkg::OP_NONE;
        endcase
      end
      hbp_pkg::S_ACQ_POP: begin
        if (!stat.idle_empty) cmd.op = hbp_pkg::OP_POP;
      end
      hbp_pkg::S_ACQ_CHK: begin
        if (stat.pop_bad) cmd.op = hbp_pkg::OP_DESTROY;
        else cmd.op = hbp_pkg::OP_GRANT;
      end
      hbp_pkg::S_ACQ_CREATE: begin
        if (stat.can_create) cmd.op = hbp_pkg::OP_CREATE;
        else cmd.op = hbp_pkg::OP_FAIL;
      end
      hbp_pkg::S_GRANT: cmd.op = hbp_pkg::OP_GRANT;
      hbp_pkg::S_REL_CHK: begin
        if (stat.rel_drop) cmd.op = hbp_pkg::OP_REL_DESTROY;
        else if (stat.qhas) cmd.op = hbp_pkg::OP_HANDOVER;
        else cmd.op = hbp_pkg::OP_IDLE_RET;
      end
      hbp_pkg::S_REFILL: begin
        if (stat.refill_need && stat.can_create) cmd.op = hbp_pkg::OP_REFILL;
      end
      hbp_pkg::S_SW_RD: begin
        if (!stat.sweep_done) cmd.op = hbp_pkg::OP_SW_RD;
      end
      hbp_pkg::S_SW_CHK: cmd.op = hbp_pkg::OP_SW_EVAL;
      hbp_pkg::S_CMP: begin
        if (stat.cmp_done) cmd.op = hbp_pkg::OP_CMP_END;
        else cmd.op = hbp_pkg::OP_CMP;
      end
      hbp_pkg::S_PW: begin
        if (stat.pw_more && stat.can_create) cmd.op = hbp_pkg::OP_PW;
      end
      hbp_pkg::S_RESP: begin
        if (stat.out_free) cmd.op = hbp_pkg::OP_RESP;
      end
      default: cmd.op = hbp_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/hbp_dp.sv =====
// ----------------------------------------------------------------------------
// hbp_dp
// pool datapath: slot states, time stamps, idle stack, wait queue, result
// ----------------------------------------------------------------------------
module hbp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [hbp_pkg::REQ_W-1:0]         in_req_type,
  input  logic [hbp_pkg::SLOT_W-1:0]        in_slot_id,
  input  logic                              in_healthy,
  input  logic [hbp_pkg::TAG_W-1:0]         in_waiter_tag,
  input  logic [hbp_pkg::MASK_W-1:0]        in_valid_mask,
  input  logic                              in_create_ok,
  input  logic [hbp_pkg::CNT_W-1:0]         in_prewarm_count,
  input  hbp_pkg::cmd_t                     cmd,
  output hbp_pkg::stat_t                    stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hbp_pkg::STAT_W-1:0]        out_status,
  output logic [hbp_pkg::SLOT_W-1:0]        out_granted_slot,
  output logic [hbp_pkg::TAG_W-1:0]         out_served_tag,
  output logic [hbp_pkg::CNT_W-1:0]         out_affected_count,
  output logic [hbp_pkg::CNT_W-1:0]         out_total_handles,
  output logic [hbp_pkg::CNT_W-1:0]         out_idle_handles,
  output logic [hbp_pkg::CNT_W-1:0]         out_active_handles,
  output logic [hbp_pkg::CNT_W-1:0]         out_waiting_requests
);

  localparam int SLOTS  = hbp_pkg::SLOTS;
  localparam int SLOT_W = hbp_pkg::SLOT_W;
  localparam int CNT_W  = hbp_pkg::CNT_W;
  localparam int TIME_W = hbp_pkg::TIME_W;
  localparam int TAG_W  = hbp_pkg::TAG_W;
  localparam int QPTR_W = hbp_pkg::QPTR_W;

  // configuration
  logic [CNT_W-1:0]  max_total_r, min_idle_r;
  logic [TIME_W-1:0] idle_to_r, max_life_r;

  // latched request
  hbp_pkg::req_t          req_r;
  logic [SLOT_W-1:0]      sid_r;
  logic                   healthy_r;
  logic [TAG_W-1:0]       tag_r;
  logic [hbp_pkg::MASK_W-1:0] mask_r;
  logic                   ok_r;
  logic [CNT_W-1:0]       pcount_r;

  // pool state
  hbp_pkg::slot_st_t slot_st_r [SLOTS];
  logic [TIME_W-1:0] created_mem [SLOTS];
  logic [TIME_W-1:0] lastu_mem [SLOTS];
  logic [TIME_W-1:0] rd_created_r, rd_last_r;
  logic [SLOT_W-1:0] stack_r [SLOTS];
  logic [CNT_W-1:0]  depth_r, total_r, active_r;
  logic [TAG_W-1:0]  fifo_r [hbp_pkg::QDEPTH];
  logic [QPTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  fill_r;
  logic [TIME_W-1:0] now_r;

  // sequencing scratch
  logic [SLOT_W-1:0] cur_r;
  logic [CNT_W-1:0]  idx_r, cj_r, cw_r, aff_r;
  logic [SLOTS-1:0]  kill_r;
  hbp_pkg::rsp_t     status_r;
  logic [SLOT_W-1:0] gslot_r;
  logic [TAG_W-1:0]  stag_r;

  // output register
  logic              out_valid_r;
  logic [hbp_pkg::STAT_W-1:0] o_status_r;
  logic [SLOT_W-1:0] o_gslot_r;
  logic [TAG_W-1:0]  o_stag_r;
  logic [CNT_W-1:0]  o_aff_r, o_total_r, o_idle_r, o_active_r, o_wait_r;

  logic [CNT_W-1:0]  cap;
  logic [SLOT_W-1:0] free_slot;
  logic              free_found;
  logic [SLOT_W-1:0] stk_raddr, stk_rdata;
  logic [SLOT_W-1:0] mem_raddr;
  logic              mem_re;
  logic              sw_kill;
  logic [CNT_W-1:0]  want;
  logic              out_free;
  logic              do_create;
  logic              lastu_we;
  logic [SLOT_W-1:0] lastu_waddr;

  assign cap = (max_total_r > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : max_total_r;
  assign want = (pcount_r != '0) ? pcount_r : min_idle_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (slot_st_r[k] == hbp_pkg::SS_FREE) begin
        free_slot  = SLOT_W'(k);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.op)
      hbp_pkg::OP_POP:   stk_raddr = SLOT_W'(depth_r - CNT_W'(1));
      hbp_pkg::OP_SW_RD: stk_raddr = SLOT_W'(idx_r - CNT_W'(1));
      default:           stk_raddr = cj_r[SLOT_W-1:0];
    endcase
  end
  assign stk_rdata = stack_r[stk_raddr];

  assign mem_re = (cmd.op == hbp_pkg::OP_POP) || (cmd.op == hbp_pkg::OP_SW_RD) ||
                  (cmd.op == hbp_pkg::OP_REL_RD);
  assign mem_raddr = (cmd.op == hbp_pkg::OP_REL_RD) ? sid_r : stk_rdata;

  assign sw_kill = (req_r == hbp_pkg::REQ_CLEANUP) ?
                   (hbp_pkg::aged(now_r, rd_last_r, idle_to_r) && (total_r > min_idle_r)) :
                   !mask_r[cur_r];

  assign do_create = (cmd.op == hbp_pkg::OP_CREATE) || (cmd.op == hbp_pkg::OP_REFILL) ||
                     (cmd.op == hbp_pkg::OP_PW);

  always_comb begin
    lastu_we    = 1'b1;
    lastu_waddr = free_slot;
    case (cmd.op)
      hbp_pkg::OP_CREATE, hbp_pkg::OP_REFILL, hbp_pkg::OP_PW: lastu_waddr = free_slot;
      hbp_pkg::OP_GRANT: lastu_waddr = cur_r;
      hbp_pkg::OP_HANDOVER, hbp_pkg::OP_IDLE_RET: lastu_waddr = sid_r;
      default: lastu_we = 1'b0;
    endcase
  end

  // time stamp memories
  always_ff @(posedge clk) begin
    if (do_create) created_mem[free_slot] <= now_r;
    if (lastu_we) lastu_mem[lastu_waddr] <= now_r;
    if (mem_re) begin
      rd_created_r <= created_mem[mem_raddr];
      rd_last_r    <= lastu_mem[mem_raddr];
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    case (cmd.op)
      hbp_pkg::OP_LOAD: begin
        req_r     <= hbp_pkg::req_t'(in_req_type);
        sid_r     <= in_slot_id;
        healthy_r <= in_healthy;
        tag_r     <= in_waiter_tag;
        mask_r    <= in_valid_mask;
        ok_r      <= in_create_ok;
        pcount_r  <= in_prewarm_count;
        status_r  <= hbp_pkg::RSP_DONE;
        gslot_r   <= '0;
        stag_r    <= in_waiter_tag;
        aff_r     <= '0;
        idx_r     <= depth_r;
        cj_r      <= '0;
        cw_r      <= '0;
        kill_r    <= '0;
      end
      hbp_pkg::OP_ENQ: begin
        fifo_r[tail_r] <= tag_r;
        status_r       <= hbp_pkg::RSP_QUEUED;
      end
      hbp_pkg::OP_QFULL:   status_r <= hbp_pkg::RSP_QUEUE_FULL;
      hbp_pkg::OP_FAIL:    status_r <= hbp_pkg::RSP_FAILED;
      hbp_pkg::OP_POP:     cur_r <= stk_rdata;
      hbp_pkg::OP_CREATE:  cur_r <= free_slot;
      hbp_pkg::OP_GRANT: begin
        status_r <= hbp_pkg::RSP_GRANTED;
        gslot_r  <= cur_r;
      end
      hbp_pkg::OP_REL_BAD:     status_r <= hbp_pkg::RSP_BAD_SLOT;
      hbp_pkg::OP_REL_DESTROY: status_r <= hbp_pkg::RSP_DESTROYED;
      hbp_pkg::OP_REFILL: begin
        stack_r[depth_r[SLOT_W-1:0]] <= free_slot;
        status_r <= hbp_pkg::RSP_REPLACED;
        gslot_r  <= free_slot;
      end
      hbp_pkg::OP_HANDOVER: begin
        stag_r   <= fifo_r[head_r];
        status_r <= hbp_pkg::RSP_TO_WAITER;
        gslot_r  <= sid_r;
      end
      hbp_pkg::OP_IDLE_RET: begin
        stack_r[depth_r[SLOT_W-1:0]] <= sid_r;
        status_r <= hbp_pkg::RSP_IDLED;
      end
      hbp_pkg::OP_SW_RD: begin
        idx_r <= idx_r - CNT_W'(1);
        cur_r <= stk_rdata;
      end
      hbp_pkg::OP_SW_EVAL: begin
        if (sw_kill) begin
          kill_r[idx_r[SLOT_W-1:0]] <= 1'b1;
          aff_r <= aff_r + CNT_W'(1);
        end
      end
      hbp_pkg::OP_CMP: begin
        if (!kill_r[cj_r[SLOT_W-1:0]]) begin
          stack_r[cw_r[SLOT_W-1:0]] <= stk_rdata;
          cw_r <= cw_r + CNT_W'(1);
        end
        cj_r <= cj_r + CNT_W'(1);
      end
      hbp_pkg::OP_PW: begin
        stack_r[depth_r[SLOT_W-1:0]] <= free_slot;
        aff_r <= aff_r + CNT_W'(1);
      end
      hbp_pkg::OP_RESP: begin
        o_status_r <= status_r;
        o_gslot_r  <= gslot_r;
        o_stag_r   <= stag_r;
        o_aff_r    <= aff_r;
        o_total_r  <= total_r;
        o_idle_r   <= depth_r;
        o_active_r <= active_r;
        o_wait_r   <= fill_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_total_r <= CNT_W'(10);
      min_idle_r  <= '0;
      idle_to_r   <= TIME_W'(30);
      max_life_r  <= TIME_W'(3600);
      for (int k = 0; k < SLOTS; k++) slot_st_r[k] <= hbp_pkg::SS_FREE;
      depth_r     <= '0;
      total_r     <= '0;
      active_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (hbp_pkg::cfg_idx_t'(cfg_idx))
          hbp_pkg::CFG_MAX_TOTAL:    max_total_r <= cfg_data[CNT_W-1:0];
          hbp_pkg::CFG_MIN_IDLE:     min_idle_r  <= cfg_data[CNT_W-1:0];
          hbp_pkg::CFG_IDLE_TIMEOUT: idle_to_r   <= cfg_data[TIME_W-1:0];
          hbp_pkg::CFG_MAX_LIFETIME: max_life_r  <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == hbp_pkg::OP_RESP) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        hbp_pkg::OP_TICK: now_r <= now_r + TIME_W'(1);
        hbp_pkg::OP_ENQ: begin
          tail_r <= tail_r + QPTR_W'(1);
          fill_r <= fill_r + CNT_W'(1);
        end
        hbp_pkg::OP_POP: depth_r <= depth_r - CNT_W'(1);
        hbp_pkg::OP_DESTROY: begin
          slot_st_r[cur_r] <= hbp_pkg::SS_FREE;
          if (total_r != '0) total_r <= total_r - CNT_W'(1);
        end
        hbp_pkg::OP_CREATE: begin
          slot_st_r[free_slot] <= hbp_pkg::SS_IDLE;
          total_r <= total_r + CNT_W'(1);
        end
        hbp_pkg::OP_GRANT: begin
          slot_st_r[cur_r] <= hbp_pkg::SS_ACTIVE;
          active_r <= active_r + CNT_W'(1);
        end
        hbp_pkg::OP_REL_DESTROY: begin
          if (active_r != '0) active_r <= active_r - CNT_W'(1);
          slot_st_r[sid_r] <= hbp_pkg::SS_FREE;
          if (total_r != '0) total_r <= total_r - CNT_W'(1);
        end
        hbp_pkg::OP_REFILL, hbp_pkg::OP_PW: begin
          slot_st_r[free_slot] <= hbp_pkg::SS_IDLE;
          total_r <= total_r + CNT_W'(1);
          depth_r <= depth_r + CNT_W'(1);
        end
        hbp_pkg::OP_HANDOVER: begin
          head_r <= head_r + QPTR_W'(1);
          fill_r <= fill_r - CNT_W'(1);
        end
        hbp_pkg::OP_IDLE_RET: begin
          if (active_r != '0) active_r <= active_r - CNT_W'(1);
          slot_st_r[sid_r] <= hbp_pkg::SS_IDLE;
          depth_r <= depth_r + CNT_W'(1);
        end
        hbp_pkg::OP_SW_EVAL: begin
          if (sw_kill) begin
            slot_st_r[cur_r] <= hbp_pkg::SS_FREE;
            if (total_r != '0) total_r <= total_r - CNT_W'(1);
          end
        end
        hbp_pkg::OP_CMP_END: depth_r <= cw_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.req         = req_r;
    stat.idle_empty  = (depth_r == '0);
    stat.under_cap   = (total_r < cap);
    stat.can_create  = ok_r && (total_r < cap) && free_found;
    stat.qfull       = (fill_r >= CNT_W'(hbp_pkg::QDEPTH));
    stat.qhas        = (fill_r != '0);
    stat.slot_active = (slot_st_r[sid_r] == hbp_pkg::SS_ACTIVE);
    stat.pop_bad     = !mask_r[cur_r] || hbp_pkg::aged(now_r, rd_created_r, max_life_r);
    stat.rel_drop    = !healthy_r || hbp_pkg::aged(now_r, rd_created_r, max_life_r);
    stat.sweep_done  = (idx_r == '0);
    stat.cmp_done    = (cj_r == depth_r);
    stat.pw_more     = (aff_r < want);
    stat.refill_need = (total_r < min_idle_r);
    stat.out_free    = out_free;
    stat.total       = total_r;
    stat.depth       = depth_r;
    stat.active      = active_r;
    stat.fill        = fill_r;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_granted_slot     = o_gslot_r;
  assign out_served_tag       = o_stag_r;
  assign out_affected_count   = o_aff_r;
  assign out_total_handles    = o_total_r;
  assign out_idle_handles     = o_idle_r;
  assign out_active_handles   = o_active_r;
  assign out_waiting_requests = o_wait_r;

endmodule

// ===== hw/rtl/resource_handle_pool.sv =====
// ----------------------------------------------------------------------------
// resource_handle_pool
// Pool of 16 handle slots with a LIFO idle stack, a FIFO wait queue and
// tick-based idle and lifetime aging. Requests arrive on in_ch as
// valid/ready transactions; each request yields exactly one result
// transaction on out_ch carrying status, slot, tag and pool counts.
// Registers are to be written on the cfg_ port only while no request
// is in flight; the block itself does not enforce this. Steps: a tick,
// enqueue or bad-release request goes straight to the output register; a
// release checks the slot and, after destroying a handle, may refill one
// idle handle; an acquire pops idle entries, destroying stale or masked
// ones, until one is granted or the stack is empty, then falls through
// to creation; health check and idle cleanup read each idle entry through
// the time stamp memory read port, then compact the stack; prewarm
// creates one handle per step. One request is in work at a time; the
// next is taken as soon as the result sits in the output register.
// When the receiver stalls, the result holds and the block finishes the
// next request, then waits until the output register is free.
// Reset empties the pool and the wait queue, zeroes the clock and loads
// the register defaults; reset is synchronous to clk.
// ----------------------------------------------------------------------------
module resource_handle_pool (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hbp_pkg::CFG_DATA_W-1:0] cfg_data,
  hbp_in_if.sink                         in_ch,
  hbp_out_if.source                      out_ch
);

  hbp_pkg::cmd_t  cmd;
  hbp_pkg::stat_t stat;

  hbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbp_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_data             (cfg_data),
    .in_req_type          (in_ch.req_type),
    .in_slot_id           (in_ch.slot_id),
    .in_healthy           (in_ch.healthy),
    .in_waiter_tag        (in_ch.waiter_tag),
    .in_valid_mask        (in_ch.valid_mask),
    .in_create_ok         (in_ch.create_ok),
    .in_prewarm_count     (in_ch.prewarm_count),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_granted_slot     (out_ch.granted_slot),
    .out_served_tag       (out_ch.served_tag),
    .out_affected_count   (out_ch.affected_count),
    .out_total_handles    (out_ch.total_handles),
    .out_idle_handles     (out_ch.idle_handles),
    .out_active_handles   (out_ch.active_handles),
    .out_waiting_requests (out_ch.waiting_requests)
  );

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> ({1'b0, stat.depth} + {1'b0, stat.active} == {1'b0, stat.total}))
    else $error("idle plus active does not match total");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= hbp_pkg::CNT_W'(hbp_pkg::QDEPTH))
    else $error("wait queue overfilled");

  a_resp_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == hbp_pkg::OP_RESP) |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending transaction");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for resource_handle_pool. An in-bench model of the pool
// (slot states, idle stack, wait queue, tick clock) predicts one result per
// accepted request. Results are checked field by field in order. Directed
// corner cases run first, then register phases with random request mixes,
// random idling on both channels, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_W      = hbp_pkg::REQ_W;
  localparam int SLOT_W     = hbp_pkg::SLOT_W;
  localparam int TAG_W      = hbp_pkg::TAG_W;
  localparam int MASK_W     = hbp_pkg::MASK_W;
  localparam int CNT_W      = hbp_pkg::CNT_W;
  localparam int STAT_W     = hbp_pkg::STAT_W;
  localparam int TIME_W     = hbp_pkg::TIME_W;
  localparam int SLOTS      = hbp_pkg::SLOTS;
  localparam int QDEPTH     = hbp_pkg::QDEPTH;
  localparam int CFG_IDX_W  = hbp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = hbp_pkg::CFG_DATA_W;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [SLOT_W-1:0] sid;
    logic              healthy;
    logic [TAG_W-1:0]  tag;
    logic [MASK_W-1:0] mask;
    logic              ok;
    logic [CNT_W-1:0]  pcount;
  } pool_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  affected;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  idle;
    logic [CNT_W-1:0]  active;
    logic [CNT_W-1:0]  waiting;
  } pool_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hbp_in_if  in_ch();
  hbp_out_if out_ch();

  resource_handle_pool dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // pool model state
  logic [4:0]           m_max_total;
  logic [4:0]           m_min_idle;
  logic [TIME_W-1:0]    m_idle_to;
  logic [TIME_W-1:0]    m_life;
  hbp_pkg::slot_st_t    m_st[SLOTS];
  logic [TIME_W-1:0]    m_born[SLOTS];
  logic [TIME_W-1:0]    m_used[SLOTS];
  logic [SLOT_W-1:0]    m_stack[SLOTS];
  int                   m_depth;
  int                   m_total;
  int                   m_active;
  logic [TAG_W-1:0]     m_waitq[$];
  logic [TIME_W-1:0]    m_now;

  pool_rsp_t expected_rsp[$];
  int  errors;
  bit  calm;
  int  hold_cnt;
  int  quiet_cycles;

  function automatic void pool_reset();
    m_max_total = 5'd10;
    m_min_idle = 5'd0;
    m_idle_to = 32'd30;
    m_life = 32'd3600;
    for (int s = 0; s < SLOTS; s++) m_st[s] = hbp_pkg::SS_FREE;
    m_depth = 0;
    m_total = 0;
    m_active = 0;
    m_waitq.delete();
    m_now = '0;
  endfunction

  function automatic int pool_cap();
    return (m_max_total > SLOTS) ? SLOTS : int'(m_max_total);
  endfunction

  function automatic bit life_over(int s);
    logic [TIME_W-1:0] age;
    age = m_now - m_born[s];
    return (m_life != '0) && (age >= m_life);
  endfunction

  function automatic bit rest_over(int s);
    logic [TIME_W-1:0] age;
    age = m_now - m_used[s];
    return (m_idle_to != '0) && (age >= m_idle_to);
  endfunction

  function automatic int make_handle(logic ok);
    if (!ok || m_total >= pool_cap()) return -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (m_st[s] == hbp_pkg::SS_FREE) begin
        m_st[s] = hbp_pkg::SS_IDLE;
        m_born[s] = m_now;
        m_used[s] = m_now;
        m_total++;
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void drop_handle(int s);
    m_st[s] = hbp_pkg::SS_FREE;
    if (m_total > 0) m_total--;
  endfunction

  function automatic void push_idle(int s);
    if (m_depth < SLOTS) begin
      m_st[s] = hbp_pkg::SS_IDLE;
      m_stack[m_depth] = SLOT_W'(s);
      m_depth++;
    end
  endfunction

  function automatic int sweep_idle(bit by_age, logic [MASK_W-1:0] mask);
    logic [SLOT_W-1:0] keep[$];
    int gone;
    int s;
    bit kill;
    gone = 0;
    for (int i = m_depth; i > 0; i--) begin
      s = m_stack[i-1];
      if (!by_age) kill = !mask[s];
      else kill = rest_over(s) && (m_total > m_min_idle);
      if (kill) begin
        drop_handle(s);
        gone++;
      end else begin
        keep.push_back(SLOT_W'(s));
      end
    end
    for (int j = 0; j < keep.size(); j++) m_stack[j] = keep[keep.size()-1-j];
    m_depth = keep.size();
    return gone;
  endfunction

  function automatic int take_handle(logic [MASK_W-1:0] mask, logic ok);
    int got;
    int s;
    got = -1;
    while (m_depth > 0) begin
      m_depth--;
      s = m_stack[m_depth];
      if (!mask[s] || life_over(s)) begin
        drop_handle(s);
        continue;
      end
      got = s;
      break;
    end
    if (got < 0) got = make_handle(ok);
    if (got >= 0) begin
      m_st[got] = hbp_pkg::SS_ACTIVE;
      m_used[got] = m_now;
      m_active++;
    end
    return got;
  endfunction

  function automatic pool_rsp_t pool_step(pool_req_t it);
    pool_rsp_t r;
    int g;
    int h;
    int want;
    r.status = hbp_pkg::RSP_DONE;
    r.slot = '0;
    r.tag = it.tag;
    r.affected = '0;
    case (it.req)
      hbp_pkg::REQ_TICK: m_now = m_now + 1'b1;
      hbp_pkg::REQ_ACQUIRE, hbp_pkg::REQ_ACQ_WAIT: begin
        if (it.req == hbp_pkg::REQ_ACQUIRE || m_depth > 0 || m_total < pool_cap()) begin
          g = take_handle(it.mask, it.ok);
          if (g >= 0) begin
            r.status = hbp_pkg::RSP_GRANTED;
            r.slot = SLOT_W'(g);
          end else begin
            r.status = hbp_pkg::RSP_FAILED;
          end
        end else if (m_waitq.size() >= QDEPTH) begin
          r.status = hbp_pkg::RSP_QUEUE_FULL;
        end else begin
          m_waitq.push_back(it.tag);
          r.status = hbp_pkg::RSP_QUEUED;
        end
      end
      hbp_pkg::REQ_RELEASE: begin
        if (m_st[it.sid] != hbp_pkg::SS_ACTIVE) begin
          r.status = hbp_pkg::RSP_BAD_SLOT;
        end else if (!it.healthy || life_over(it.sid)) begin
          if (m_active > 0) m_active--;
          drop_handle(it.sid);
          r.status = hbp_pkg::RSP_DESTROYED;
          if (m_total < m_min_idle) begin
            g = make_handle(it.ok);
            if (g >= 0) begin
              push_idle(g);
              r.status = hbp_pkg::RSP_REPLACED;
              r.slot = SLOT_W'(g);
            end
          end
        end else if (m_waitq.size() > 0) begin
          r.tag = m_waitq.pop_front();
          m_used[it.sid] = m_now;
          r.status = hbp_pkg::RSP_TO_WAITER;
          r.slot = it.sid;
        end else begin
          m_used[it.sid] = m_now;
          if (m_active > 0) m_active--;
          push_idle(it.sid);
          r.status = hbp_pkg::RSP_IDLED;
        end
      end
      hbp_pkg::REQ_HEALTH: r.affected = CNT_W'(sweep_idle(1'b0, it.mask));
      hbp_pkg::REQ_CLEANUP: r.affected = CNT_W'(sweep_idle(1'b1, it.mask));
      hbp_pkg::REQ_PREWARM: begin
        want = (it.pcount != 0) ? int'(it.pcount) : int'(m_min_idle);
        g = 0;
        while (g < want && m_total < pool_cap()) begin
          h = make_handle(it.ok);
          if (h < 0) break;
          push_idle(h);
          g++;
        end
        r.affected = CNT_W'(g);
      end
      default: ;
    endcase
    r.total = CNT_W'(m_total);
    r.idle = CNT_W'(m_depth);
    r.active = CNT_W'(m_active);
    r.waiting = CNT_W'(m_waitq.size());
    return r;
  endfunction

  // receiver side: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ch.ready = 1'b0;
      hold_cnt--;
    end else begin
      out_ch.ready = calm || ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk) begin
    pool_rsp_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result transaction, status %0d", out_ch.status);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.granted_slot !== e.slot) begin
          $error("granted_slot: expected %0d, got %0d", e.slot, out_ch.granted_slot);
          errors++;
        end
        if (out_ch.served_tag !== e.tag) begin
          $error("served_tag: expected %0d, got %0d", e.tag, out_ch.served_tag);
          errors++;
        end
        if (out_ch.affected_count !== e.affected) begin
          $error("affected_count: expected %0d, got %0d", e.affected,
                 out_ch.affected_count);
          errors++;
        end
        if (out_ch.total_handles !== e.total) begin
          $error("total_handles: expected %0d, got %0d", e.total, out_ch.total_handles);
          errors++;
        end
        if (out_ch.idle_handles !== e.idle) begin
          $error("idle_handles: expected %0d, got %0d", e.idle, out_ch.idle_handles);
          errors++;
        end
        if (out_ch.active_handles !== e.active) begin
          $error("active_handles: expected %0d, got %0d", e.active,
                 out_ch.active_handles);
          errors++;
        end
        if (out_ch.waiting_requests !== e.waiting) begin
          $error("waiting_requests: expected %0d, got %0d", e.waiting,
                 out_ch.waiting_requests);
          errors++;
        end
      end
    end
  end

  // watchdog on transaction progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("resource_handle_pool regression: fail");
        $finish;
      end
    end
  end

  task automatic send_req(pool_req_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.req_type = it.req;
    in_ch.slot_id = it.sid;
    in_ch.healthy = it.healthy;
    in_ch.waiter_tag = it.tag;
    in_ch.valid_mask = it.mask;
    in_ch.create_ok = it.ok;
    in_ch.prewarm_count = it.pcount;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_rsp.push_back(pool_step(it));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(hbp_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      hbp_pkg::CFG_MAX_TOTAL: m_max_total = val[4:0];
      hbp_pkg::CFG_MIN_IDLE: m_min_idle = val[4:0];
      hbp_pkg::CFG_IDLE_TIMEOUT: m_idle_to = val;
      hbp_pkg::CFG_MAX_LIFETIME: m_life = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_pool(logic [CFG_DATA_W-1:0] mt, logic [CFG_DATA_W-1:0] mi,
                          logic [CFG_DATA_W-1:0] ito, logic [CFG_DATA_W-1:0] lt);
    drain();
    write_reg(hbp_pkg::CFG_MAX_TOTAL, mt);
    write_reg(hbp_pkg::CFG_MIN_IDLE, mi);
    write_reg(hbp_pkg::CFG_IDLE_TIMEOUT, ito);
    write_reg(hbp_pkg::CFG_MAX_LIFETIME, lt);
  endtask

  function automatic pool_req_t mk_req(logic [REQ_W-1:0] req);
    pool_req_t it;
    it.req = req;
    it.sid = SLOT_W'($urandom_range(0, 15));
    it.healthy = 1'b1;
    it.tag = TAG_W'($urandom_range(0, 255));
    it.mask = 16'hffff;
    it.ok = 1'b1;
    it.pcount = 5'd0;
    return it;
  endfunction

  function automatic pool_req_t rand_req();
    pool_req_t it;
    int pick;
    int busy[$];
    pick = $urandom_range(0, 99);
    if (pick < 20) it = mk_req(hbp_pkg::REQ_TICK);
    else if (pick < 38) it = mk_req(hbp_pkg::REQ_ACQUIRE);
    else if (pick < 53) it = mk_req(hbp_pkg::REQ_ACQ_WAIT);
    else if (pick < 80) it = mk_req(hbp_pkg::REQ_RELEASE);
    else if (pick < 85) it = mk_req(hbp_pkg::REQ_HEALTH);
    else if (pick < 92) it = mk_req(hbp_pkg::REQ_CLEANUP);
    else if (pick < 99) it = mk_req(hbp_pkg::REQ_PREWARM);
    else it = mk_req(REQ_UNKNOWN);
    if ($urandom_range(0, 99) < 15) it.mask = MASK_W'($urandom_range(0, 16'hffff));
    it.ok = ($urandom_range(0, 99) >= 10);
    it.healthy = ($urandom_range(0, 99) >= 15);
    it.pcount = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(17, 31)) :
                CNT_W'($urandom_range(0, 16));
    if (it.req == hbp_pkg::REQ_RELEASE) begin
      for (int s = 0; s < SLOTS; s++) if (m_st[s] == hbp_pkg::SS_ACTIVE) busy.push_back(s);
      if (busy.size() > 0 && $urandom_range(0, 99) < 90)
        it.sid = SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]);
    end
    return it;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) calm = 1'b1;
      if (n == count / 3 + 40) calm = 1'b0;
      send_req(rand_req());
    end
  endtask

  task automatic test_directed();
    pool_req_t it;
    it = mk_req(hbp_pkg::REQ_PREWARM);
    send_req(it);
    it = mk_req(hbp_pkg::REQ_RELEASE);
    it.sid = 4'd15;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_ACQUIRE);
    it.ok = 1'b0;
    send_req(it);
    send_req(mk_req(hbp_pkg::REQ_ACQUIRE));
    it = mk_req(hbp_pkg::REQ_ACQ_WAIT);
    it.tag = 8'hff;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_RELEASE);
    it.sid = 4'd0;
    send_req(it);
    it.sid = 4'd1;
    it.healthy = 1'b0;
    send_req(it);
    send_req(mk_req(REQ_UNKNOWN));
    it = mk_req(hbp_pkg::REQ_PREWARM);
    it.pcount = 5'd31;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_HEALTH);
    it.mask = 16'h5555;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_ACQUIRE);
    it.mask = 16'h0000;
    send_req(it);
    it.mask = 16'hffff;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_CLEANUP);
    send_req(it);
    set_pool(10, 2, 30, 3600);
    it = mk_req(hbp_pkg::REQ_RELEASE);
    it.sid = m_stack[0];
    for (int s = 0; s < SLOTS; s++) if (m_st[s] == hbp_pkg::SS_ACTIVE) it.sid = SLOT_W'(s);
    it.healthy = 1'b0;
    send_req(it);
    it = mk_req(hbp_pkg::REQ_TICK);
    send_req(it);
    send_req(mk_req(hbp_pkg::REQ_PREWARM));
  endtask

  task automatic test_wait_queue();
    pool_req_t it;
    set_pool(1, 0, 0, 0);
    send_req(mk_req(hbp_pkg::REQ_ACQUIRE));
    for (int n = 0; n < 18; n++) send_req(mk_req(hbp_pkg::REQ_ACQ_WAIT));
    for (int n = 0; n < 18; n++) begin
      it = mk_req(hbp_pkg::REQ_RELEASE);
      for (int s = 0; s < SLOTS; s++) if (m_st[s] == hbp_pkg::SS_ACTIVE) it.sid = SLOT_W'(s);
      send_req(it);
    end
  endtask

  task automatic test_backpressure();
    set_pool(16, 4, 12, 40);
    @(negedge clk);
    hold_cnt = 400;
    for (int n = 0; n < 12; n++) send_req(rand_req());
    run_random(100);
  endtask

  task automatic test_phases();
    set_pool(16, 4, 12, 40);
    run_random(170);
    set_pool(2, 0, 0, 0);
    run_random(170);
    set_pool(31, 16, 1, 1);
    run_random(150);
    set_pool(0, 0, 32'hffff_ffff, 32'hffff_ffff);
    run_random(60);
    set_pool(5, 2, 20, 100);
    run_random(170);
    set_pool(3, 1, 8, 25);
    run_random(170);
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.slot_id = '0;
    in_ch.healthy = 1'b0;
    in_ch.waiter_tag = '0;
    in_ch.valid_mask = '0;
    in_ch.create_ok = 1'b0;
    in_ch.prewarm_count = '0;
    pool_reset();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_wait_queue();
    test_phases();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("resource_handle_pool regression: pass");
    end else begin
      $display("resource_handle_pool regression: fail");
    end
    $finish;
  end

endmodule
